// ===== hw/rtl/sit_pkg.sv =====
`default_nettype none

package sit_pkg;

  // Coordinates are taken from the low COORD_BITS bits of each field, sign-extended.
  localparam int FIELD_BITS = 32;
  localparam int COORD_BITS = 32;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int SUM_BITS   = PROD_BITS + 1;
  localparam int CLASS_BITS = 3;

  typedef logic signed [FIELD_BITS-1:0] field_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;

  typedef enum logic [CLASS_BITS-1:0] {
    CLS_CCW    = 3'd0,
    CLS_CW     = 3'd1,
    CLS_BEHIND = 3'd2,
    CLS_BEYOND = 3'd3,
    CLS_ON     = 3'd4
  } class_e;

  typedef struct packed {
    diff_t x;
    diff_t y;
  } vec_t;

  function automatic coord_t to_coord(field_t f);
    return coord_t'(f[COORD_BITS-1:0]);
  endfunction

  function automatic diff_t sub(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  // xprod/dot are u x v and u . v, lu is |u|^2.
  // For a collinear point with dot >= 0, v = t*u, so beyond <=> dot > |u|^2,
  // except for a degenerate segment, where any point off the end is beyond.
  function automatic class_e classify(sum_t xprod, sum_t dot, sum_t lu,
                                      logic u_zero, logic v_zero);
    class_e c;
    if (xprod > 0) begin
      c = CLS_CCW;
    end else if (xprod < 0) begin
      c = CLS_CW;
    end else if (dot < 0) begin
      c = CLS_BEHIND;
    end else if (u_zero) begin
      c = v_zero ? CLS_ON : CLS_BEYOND;
    end else begin
      c = (dot > lu) ? CLS_BEYOND : CLS_ON;
    end
    return c;
  endfunction

  // Signed codes: ccw/behind positive, cw/beyond negative, on zero.
  function automatic logic straddles(class_e a, class_e b);
    logic a_pos;
    logic b_pos;
    a_pos = (a == CLS_CCW) || (a == CLS_BEHIND);
    b_pos = (b == CLS_CCW) || (b == CLS_BEHIND);
    return (a == CLS_ON) || (b == CLS_ON) || (a_pos != b_pos);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sit_sqlen.sv =====
`default_nettype none

// Squared length of a segment vector: products registered, then sum registered.
module sit_sqlen (
  input  wire logic          clk_i,
  input  wire sit_pkg::vec_t u_i,
  output sit_pkg::sum_t      lu_o
);
  import sit_pkg::*;

  prod_t xx_d, yy_d, xx_q, yy_q;
  sum_t  lu_d, lu_q;

  always_comb begin
    xx_d = u_i.x * u_i.x;
    yy_d = u_i.y * u_i.y;
    lu_d = sum_t'(xx_q) + sum_t'(yy_q);
  end

  always_ff @(posedge clk_i) begin
    xx_q <= xx_d;
    yy_q <= yy_d;
    lu_q <= lu_d;
  end

  assign lu_o = lu_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sit_orient.sv =====
`default_nettype none

// One orientation test of point (base + v) against segment vector u.
// Products registered, then sums registered; class is combinational on the sums.
module sit_orient (
  input  wire logic          clk_i,
  input  wire sit_pkg::vec_t u_i,
  input  wire sit_pkg::vec_t v_i,
  input  wire sit_pkg::sum_t lu_i,
  output sit_pkg::class_e    cls_o
);
  import sit_pkg::*;

  prod_t xy_d, yx_d, xx_d, yy_d;
  prod_t xy_q, yx_q, xx_q, yy_q;
  sum_t  cross_d, dot_d, cross_q, dot_q;
  logic  uz_d, vz_d;
  logic  uz2_q, vz2_q, uz3_q, vz3_q;

  always_comb begin
    xy_d    = u_i.x * v_i.y;
    yx_d    = u_i.y * v_i.x;
    xx_d    = u_i.x * v_i.x;
    yy_d    = u_i.y * v_i.y;
    uz_d    = (u_i.x == '0) && (u_i.y == '0);
    vz_d    = (v_i.x == '0) && (v_i.y == '0);
    cross_d = sum_t'(xy_q) - sum_t'(yx_q);
    dot_d   = sum_t'(xx_q) + sum_t'(yy_q);
  end

  always_ff @(posedge clk_i) begin
    xy_q    <= xy_d;
    yx_q    <= yx_d;
    xx_q    <= xx_d;
    yy_q    <= yy_d;
    uz2_q   <= uz_d;
    vz2_q   <= vz_d;
    cross_q <= cross_d;
    dot_q   <= dot_d;
    uz3_q   <= uz2_q;
    vz3_q   <= vz2_q;
  end

  assign cls_o = classify(cross_q, dot_q, lu_i, uz3_q, vz3_q);

endmodule

`default_nettype wire

// ===== hw/rtl/segment_intersection_test_core.sv =====
`default_nettype none

// Closed segment intersection test. Raise start with the two segments' eight
// coordinates; busy is always low, so a new pair is taken every cycle. Each
// pair gives one result through the input register, difference stage,
// multiplier stage, adder stage and result register, shown with done_o high
// for one cycle; the receiver cannot stall and must take it then. Throughput is
// one pair per clock, set by the fully pipelined multiplier stage (20 signed
// 33x33 products). Each class output is 0 ccw, 1 cw, 2 collinear behind the
// start, 3 collinear beyond the end, 4 on the segment; intersects_o is 1 when
// both segments see the other's end points on opposite sides or on them.
// Only the low COORD_BITS bits of each coordinate count, sign-extended.
module segment_intersection_test_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [sit_pkg::FIELD_BITS-1:0] seg1_start_x_i,
  input  wire logic signed [sit_pkg::FIELD_BITS-1:0] seg1_start_y_i,
  input  wire logic signed [sit_pkg::FIELD_BITS-1:0] seg1_end_x_i,
  input  wire logic signed [sit_pkg::FIELD_BITS-1:0] seg1_end_y_i,
  input  wire logic signed [sit_pkg::FIELD_BITS-1:0] seg2_start_x_i,
  input  wire logic signed [sit_pkg::FIELD_BITS-1:0] seg2_start_y_i,
  input  wire logic signed [sit_pkg::FIELD_BITS-1:0] seg2_end_x_i,
  input  wire logic signed [sit_pkg::FIELD_BITS-1:0] seg2_end_y_i,
  output logic                                    done_o,
  output logic                                    intersects_o,
  output logic [sit_pkg::CLASS_BITS-1:0]          class_s1_p3_o,
  output logic [sit_pkg::CLASS_BITS-1:0]          class_s1_p4_o,
  output logic [sit_pkg::CLASS_BITS-1:0]          class_s2_p1_o,
  output logic [sit_pkg::CLASS_BITS-1:0]          class_s2_p2_o
);
  import sit_pkg::*;

  logic accept;

  // valid bits per stage
  logic v0_q, v1_q, v2_q, v3_q, done_q;

  // input register
  coord_t p1x_q, p1y_q, p2x_q, p2y_q, p3x_q, p3y_q, p4x_q, p4y_q;

  // difference stage: seg1 based at p1, seg2 based at p3
  vec_t u1_d, v13_d, v14_d, u2_d, v21_d, v22_d;
  vec_t u1_q, v13_q, v14_q, u2_q, v21_q, v22_q;

  sum_t   lu1, lu2;
  class_e c3, c4, c1, c2;
  logic   hit_d;

  class_e c3_q, c4_q, c1_q, c2_q;
  logic   hit_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v0_q   <= accept;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= v3_q;
    end
  end

  // payload: no reset, qualified by the valid pipe
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1x_q <= to_coord(seg1_start_x_i);
      p1y_q <= to_coord(seg1_start_y_i);
      p2x_q <= to_coord(seg1_end_x_i);
      p2y_q <= to_coord(seg1_end_y_i);
      p3x_q <= to_coord(seg2_start_x_i);
      p3y_q <= to_coord(seg2_start_y_i);
      p4x_q <= to_coord(seg2_end_x_i);
      p4y_q <= to_coord(seg2_end_y_i);
    end
  end

  always_comb begin
    u1_d  = '{x: sub(p2x_q, p1x_q), y: sub(p2y_q, p1y_q)};
    v13_d = '{x: sub(p3x_q, p1x_q), y: sub(p3y_q, p1y_q)};
    v14_d = '{x: sub(p4x_q, p1x_q), y: sub(p4y_q, p1y_q)};
    u2_d  = '{x: sub(p4x_q, p3x_q), y: sub(p4y_q, p3y_q)};
    v21_d = '{x: sub(p1x_q, p3x_q), y: sub(p1y_q, p3y_q)};
    v22_d = '{x: sub(p2x_q, p3x_q), y: sub(p2y_q, p3y_q)};
  end

  always_ff @(posedge clk_i) begin
    u1_q  <= u1_d;
    v13_q <= v13_d;
    v14_q <= v14_d;
    u2_q  <= u2_d;
    v21_q <= v21_d;
    v22_q <= v22_d;
  end

  // squared segment lengths, shared by the two tests on each segment
  sit_sqlen u_len1 (.clk_i(clk_i), .u_i(u1_q), .lu_o(lu1));
  sit_sqlen u_len2 (.clk_i(clk_i), .u_i(u2_q), .lu_o(lu2));

  sit_orient u_or3 (.clk_i(clk_i), .u_i(u1_q), .v_i(v13_q), .lu_i(lu1), .cls_o(c3));
  sit_orient u_or4 (.clk_i(clk_i), .u_i(u1_q), .v_i(v14_q), .lu_i(lu1), .cls_o(c4));
  sit_orient u_or1 (.clk_i(clk_i), .u_i(u2_q), .v_i(v21_q), .lu_i(lu2), .cls_o(c1));
  sit_orient u_or2 (.clk_i(clk_i), .u_i(u2_q), .v_i(v22_q), .lu_i(lu2), .cls_o(c2));

  assign hit_d = straddles(c3, c4) && straddles(c1, c2);

  // result register
  always_ff @(posedge clk_i) begin
    c3_q  <= c3;
    c4_q  <= c4;
    c1_q  <= c1;
    c2_q  <= c2;
    hit_q <= hit_d;
  end

  assign done_o        = done_q;
  assign intersects_o  = hit_q;
  assign class_s1_p3_o = c3_q;
  assign class_s1_p4_o = c4_q;
  assign class_s2_p1_o = c1_q;
  assign class_s2_p2_o = c2_q;

  // every request gives a result strobe on done_o
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 done_o)
    else $error("result missing after request");

  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 5))
    else $error("result without request");

  // an end point lying on the other segment always counts as a touch
  a_on_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (class_s1_p3_o == CLS_ON) && (class_s2_p1_o == CLS_ON) |-> intersects_o)
    else $error("shared point not reported as intersection");

  // both ends of seg2 strictly on the ccw side of seg1 means no intersection
  a_same_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (class_s1_p3_o == CLS_CCW) && (class_s1_p4_o == CLS_CCW) |-> !intersects_o)
    else $error("intersection reported with seg2 on one side");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Quiet cycles tolerated before the run is declared hung. The worst honest
  // gap is a sender pause of a few cycles plus the five-stage pipeline.
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned MAX_REPORTS  = 100;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned NUM_PHASES   = 4;
  localparam int unsigned PHASE_PAIRS  = 290;

  localparam sit_pkg::field_t FMAX = 32'h7fff_ffff;
  localparam sit_pkg::field_t FMIN = 32'h8000_0000;

  // Exact width for cross/dot products and squared lengths.
  typedef logic signed [127:0] wide_t;

  typedef struct {
    sit_pkg::field_t s1_sx, s1_sy, s1_ex, s1_ey;
    sit_pkg::field_t s2_sx, s2_sy, s2_ex, s2_ey;
  } seg_pair_t;

  typedef struct {
    logic                          intersects;
    logic [sit_pkg::CLASS_BITS-1:0] s1_p3;
    logic [sit_pkg::CLASS_BITS-1:0] s1_p4;
    logic [sit_pkg::CLASS_BITS-1:0] s2_p1;
    logic [sit_pkg::CLASS_BITS-1:0] s2_p2;
  } verdict_t;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Only the low COORD_BITS bits count, sign-extended.
  function automatic longint coord_of(sit_pkg::field_t f);
    logic signed [sit_pkg::COORD_BITS-1:0] c;
    c = f[sit_pkg::COORD_BITS-1:0];
    return c;
  endfunction

  // Where point p lies relative to segment a->b.
  function automatic sit_pkg::class_e locate_point(longint ax, longint ay,
                                                   longint bx, longint by,
                                                   longint px, longint py);
    wide_t ux, uy, vx, vy;
    wide_t xprod, dot, len_u, len_v;
    ux = bx - ax;
    uy = by - ay;
    vx = px - ax;
    vy = py - ay;
    xprod = ux * vy - uy * vx;
    if (xprod > 0) return sit_pkg::CLS_CCW;
    if (xprod < 0) return sit_pkg::CLS_CW;
    dot = ux * vx + uy * vy;
    if (dot < 0) return sit_pkg::CLS_BEHIND;
    // Collinear and not behind: further from the start than the end is beyond.
    // A degenerate segment has len_u == 0, so any distinct point is beyond.
    len_u = ux * ux + uy * uy;
    len_v = vx * vx + vy * vy;
    if (len_v > len_u) return sit_pkg::CLS_BEYOND;
    return sit_pkg::CLS_ON;
  endfunction

  // ccw/behind count as one side, cw/beyond as the other, on as neither.
  function automatic int side_of(sit_pkg::class_e c);
    case (c)
      sit_pkg::CLS_CCW, sit_pkg::CLS_BEHIND: return 1;
      sit_pkg::CLS_CW, sit_pkg::CLS_BEYOND:  return -1;
      default:                               return 0;
    endcase
  endfunction

  function automatic verdict_t predict_verdict(seg_pair_t p);
    verdict_t v;
    longint ax, ay, bx, by, cx, cy, dx, dy;
    sit_pkg::class_e c3, c4, c1, c2;
    ax = coord_of(p.s1_sx);
    ay = coord_of(p.s1_sy);
    bx = coord_of(p.s1_ex);
    by = coord_of(p.s1_ey);
    cx = coord_of(p.s2_sx);
    cy = coord_of(p.s2_sy);
    dx = coord_of(p.s2_ex);
    dy = coord_of(p.s2_ey);
    c3 = locate_point(ax, ay, bx, by, cx, cy);
    c4 = locate_point(ax, ay, bx, by, dx, dy);
    c1 = locate_point(cx, cy, dx, dy, ax, ay);
    c2 = locate_point(cx, cy, dx, dy, bx, by);
    v.intersects = (side_of(c3) * side_of(c4) <= 0) && (side_of(c1) * side_of(c2) <= 0);
    v.s1_p3 = c3;
    v.s1_p4 = c4;
    v.s2_p1 = c1;
    v.s2_p2 = c2;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: expected verdicts in request order, compared per field
  // ---------------------------------------------------------------------------
  class pair_scoreboard;
    verdict_t    verdict_q[$];
    int unsigned n_pairs;
    int unsigned n_checked;
    int unsigned n_hits;
    int unsigned n_errors;
    int unsigned class_tally [5];

    function int unsigned pending();
      return verdict_q.size();
    endfunction

    function void note_request(seg_pair_t p);
      verdict_q = {verdict_q, predict_verdict(p)};
      n_pairs++;
    endfunction

    task report_mismatch(string msg);
      n_errors++;
      if (n_errors <= MAX_REPORTS) begin
        $display("%0t ns: MISMATCH %0d: %s", $realtime, n_errors, msg);
      end
    endtask

    task check_field(string name, logic [2:0] got, logic [2:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                  n_checked, name, got, want));
      end
    endtask

    task check_verdict(verdict_t got);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
        return;
      end
      want = verdict_q.pop_front();
      check_field("intersects", 3'(got.intersects), 3'(want.intersects));
      check_field("class_s1_p3", got.s1_p3, want.s1_p3);
      check_field("class_s1_p4", got.s1_p4, want.s1_p4);
      check_field("class_s2_p1", got.s2_p1, want.s2_p1);
      check_field("class_s2_p2", got.s2_p2, want.s2_p2);
      n_hits += want.intersects;
      class_tally[want.s1_p3]++;
      class_tally[want.s1_p4]++;
      class_tally[want.s2_p1]++;
      class_tally[want.s2_p2]++;
      n_checked++;
    endtask
  endclass

  pair_scoreboard sb = new();

  // ---------------------------------------------------------------------------
  // DUT and its pins; every input known from time zero
  // ---------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  sit_pkg::field_t seg1_start_x = '0, seg1_start_y = '0;
  sit_pkg::field_t seg1_end_x = '0, seg1_end_y = '0;
  sit_pkg::field_t seg2_start_x = '0, seg2_start_y = '0;
  sit_pkg::field_t seg2_end_x = '0, seg2_end_y = '0;
  logic done_o;
  logic intersects_o;
  logic [sit_pkg::CLASS_BITS-1:0] class_s1_p3_o, class_s1_p4_o;
  logic [sit_pkg::CLASS_BITS-1:0] class_s2_p1_o, class_s2_p2_o;

  segment_intersection_test_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .seg1_start_x_i (seg1_start_x),
    .seg1_start_y_i (seg1_start_y),
    .seg1_end_x_i   (seg1_end_x),
    .seg1_end_y_i   (seg1_end_y),
    .seg2_start_x_i (seg2_start_x),
    .seg2_start_y_i (seg2_start_y),
    .seg2_end_x_i   (seg2_end_x),
    .seg2_end_y_i   (seg2_end_y),
    .done_o         (done_o),
    .intersects_o   (intersects_o),
    .class_s1_p3_o  (class_s1_p3_o),
    .class_s1_p4_o  (class_s1_p4_o),
    .class_s2_p1_o  (class_s2_p1_o),
    .class_s2_p2_o  (class_s2_p2_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Monitor. Everything is driven with NBAs at the rising edge, so reading at
  // the edge sees the values that the edge itself samples.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    verdict_t got;
    seg_pair_t req;
    if (rst_ni) begin
      // Results belong to earlier requests; check them first.
      if (done_o) begin
        got.intersects = intersects_o;
        got.s1_p3 = class_s1_p3_o;
        got.s1_p4 = class_s1_p4_o;
        got.s2_p1 = class_s2_p1_o;
        got.s2_p2 = class_s2_p2_o;
        sb.check_verdict(got);
      end
      if (start && !busy) begin
        req.s1_sx = seg1_start_x;
        req.s1_sy = seg1_start_y;
        req.s1_ex = seg1_end_x;
        req.s1_ey = seg1_end_y;
        req.s2_sx = seg2_start_x;
        req.s2_sy = seg2_start_y;
        req.s2_ex = seg2_end_x;
        req.s2_ey = seg2_end_y;
        sb.note_request(req);
      end
    end
  end

  // Watchdog: ends the run if neither a request nor a result moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) quiet = 0;
      else quiet++;
    end
    $display("%0t ns: no request or result for %0d cycles", $realtime, STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver tasks. Each is entered right after a rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_pair(seg_pair_t p);
    seg1_start_x <= p.s1_sx;
    seg1_start_y <= p.s1_sy;
    seg1_end_x   <= p.s1_ex;
    seg1_end_y   <= p.s1_ey;
    seg2_start_x <= p.s2_sx;
    seg2_start_y <= p.s2_sy;
    seg2_end_x   <= p.s2_ex;
    seg2_end_y   <= p.s2_ey;
    start        <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Hold off until every outstanding request has produced its result.
  // The first edge lets the monitor log the request just accepted.
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generators
  // ---------------------------------------------------------------------------
  function automatic seg_pair_t make_pair(sit_pkg::field_t ax, sit_pkg::field_t ay,
                                          sit_pkg::field_t bx, sit_pkg::field_t by,
                                          sit_pkg::field_t cx, sit_pkg::field_t cy,
                                          sit_pkg::field_t dx, sit_pkg::field_t dy);
    seg_pair_t p;
    p.s1_sx = ax;
    p.s1_sy = ay;
    p.s1_ex = bx;
    p.s1_ey = by;
    p.s2_sx = cx;
    p.s2_sy = cy;
    p.s2_ex = dx;
    p.s2_ey = dy;
    return p;
  endfunction

  function automatic sit_pkg::field_t tiny_coord();
    return sit_pkg::field_t'(int'($urandom_range(0, 16)) - 8);
  endfunction

  function automatic sit_pkg::field_t edge_coord();
    case ($urandom_range(0, 6))
      0:       return FMIN;
      1:       return FMAX;
      2:       return '0;
      3:       return -1;
      4:       return 1;
      5:       return FMIN + 1;
      default: return FMAX - 1;
    endcase
  endfunction

  // Mix: raw noise, tiny grids (lots of collinear and shared points), points on
  // one line, extreme values, and pairs that share or collapse end points.
  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int unsigned mode;
    longint bx, by, dx, dy, scale;
    longint t [4];
    mode = $urandom_range(0, 99);
    if (mode < 25) begin
      p = make_pair($urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom);
    end else if (mode < 50) begin
      p = make_pair(tiny_coord(), tiny_coord(), tiny_coord(), tiny_coord(),
                    tiny_coord(), tiny_coord(), tiny_coord(), tiny_coord());
    end else if (mode < 75) begin
      if ($urandom_range(0, 1)) begin
        bx = coord_of(tiny_coord());
        by = coord_of(tiny_coord());
      end else begin
        bx = longint'($urandom_range(0, 32'h7fff_ffff)) - 64'sd1073741824;
        by = longint'($urandom_range(0, 32'h7fff_ffff)) - 64'sd1073741824;
      end
      dx = longint'($urandom_range(0, 6)) - 3;
      dy = longint'($urandom_range(0, 6)) - 3;
      scale = $urandom_range(0, 1) ? 1 : longint'($urandom_range(1, 65536));
      foreach (t[i]) t[i] = (longint'($urandom_range(0, 8)) - 4) * scale;
      p = make_pair(sit_pkg::field_t'(bx + t[0] * dx), sit_pkg::field_t'(by + t[0] * dy),
                    sit_pkg::field_t'(bx + t[1] * dx), sit_pkg::field_t'(by + t[1] * dy),
                    sit_pkg::field_t'(bx + t[2] * dx), sit_pkg::field_t'(by + t[2] * dy),
                    sit_pkg::field_t'(bx + t[3] * dx), sit_pkg::field_t'(by + t[3] * dy));
    end else if (mode < 85) begin
      p = make_pair(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                    edge_coord(), edge_coord(), edge_coord(), edge_coord());
    end else begin
      p = make_pair(tiny_coord(), tiny_coord(), tiny_coord(), tiny_coord(),
                    tiny_coord(), tiny_coord(), tiny_coord(), tiny_coord());
      case ($urandom_range(0, 3))
        0: begin
          p.s2_sx = p.s1_ex;
          p.s2_sy = p.s1_ey;
        end
        1: begin
          p.s2_ex = p.s1_sx;
          p.s2_ey = p.s1_sy;
        end
        2: begin
          p.s1_ex = p.s1_sx;
          p.s1_ey = p.s1_sy;
        end
        default: begin
          p.s2_ex = p.s2_sx;
          p.s2_ey = p.s2_sy;
        end
      endcase
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned idle_pct [NUM_PHASES];
    idle_pct = '{0, 74, 8, 0};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pairs, back to back.
    // Both segments collapsed onto one point, at zero and at each extreme.
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(FMAX, FMAX, FMAX, FMAX, FMAX, FMAX, FMAX, FMAX));
    send_pair(make_pair(FMIN, FMIN, FMIN, FMIN, FMIN, FMIN, FMIN, FMIN));
    // Full-range diagonals crossing, seg2 in both directions.
    send_pair(make_pair(FMIN, FMIN, FMAX, FMAX, FMIN, FMAX, FMAX, FMIN));
    send_pair(make_pair(FMIN, FMIN, FMAX, FMAX, FMAX, FMIN, FMIN, FMAX));
    // Plain crossing; parallel lines (no hit).
    send_pair(make_pair(0, 0, 4, 0, 2, -2, 2, 2));
    send_pair(make_pair(0, 0, 4, 0, 0, 1, 4, 1));
    // Collinear disjoint, collinear overlapping.
    send_pair(make_pair(0, 0, 2, 0, 4, 0, 6, 0));
    send_pair(make_pair(0, 0, 4, 0, 2, 0, 6, 0));
    // Touching at a shared end point; T junction.
    send_pair(make_pair(0, 0, 2, 2, 2, 2, 4, 0));
    send_pair(make_pair(0, 0, 4, 0, 2, 0, 2, 3));
    // Degenerate seg1: on seg2, beyond it, behind it.
    send_pair(make_pair(1, 1, 1, 1, 0, 0, 2, 2));
    send_pair(make_pair(5, 5, 5, 5, 0, 0, 2, 2));
    send_pair(make_pair(-1, -1, -1, -1, 0, 0, 2, 2));
    // Two distinct degenerate segments.
    send_pair(make_pair(1, 2, 1, 2, 3, 4, 3, 4));
    // Segments spanning the full range, the first collinear along an axis.
    send_pair(make_pair(FMIN, 0, FMAX, 0, 0, 0, FMAX, 0));
    send_pair(make_pair(FMAX, FMIN, FMIN, FMAX, 0, 0, FMIN, FMIN));
    send_pair(make_pair(-1, -1, FMIN, FMAX, FMAX, FMIN, 0, 0));
    // Near miss: one unit off the long diagonal.
    send_pair(make_pair(FMIN, FMIN, FMAX, FMAX - 1, 0, 0, 0, 0));
    // Just past the end point, on the extended line; then a full-range miss.
    send_pair(make_pair(0, 0, 4, 4, 5, 5, 6, 7));
    send_pair(make_pair(FMAX, 0, 0, FMAX, FMIN, FMIN, -1, -1));
    wait_for_results();

    // Random phases at different sender pacing; drain fully between phases.
    // Each cycle idles with the phase's percentage, so that share of cycles is idle.
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      for (int unsigned n = 0; n < PHASE_PAIRS; n++) begin
        while ($urandom_range(0, 99) < idle_pct[ph]) pause_sender(1);
        send_pair(random_pair());
      end
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    end

    $display("Covered %0d segment pairs (directed plus %0d paced phases), %0d intersecting",
             sb.n_checked, NUM_PHASES, sb.n_hits);
    $display("Classes seen: ccw %0d, cw %0d, behind %0d, beyond %0d, on %0d; mismatches %0d",
             sb.class_tally[sit_pkg::CLS_CCW], sb.class_tally[sit_pkg::CLS_CW],
             sb.class_tally[sit_pkg::CLS_BEHIND], sb.class_tally[sit_pkg::CLS_BEYOND],
             sb.class_tally[sit_pkg::CLS_ON], sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
